// File: hdl/awrc_pkg.sv
package awrc_pkg;

    // Field widths fixed by the sample format.
    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int LANES   = 3;
    localparam int COUNT_W = 2;
    localparam int BPS_W   = 2;

    // Output sample width codes for the bytes_per_sample register.
    localparam logic [BPS_W-1:0] BPS_TWO   = 2'd2;
    localparam logic [BPS_W-1:0] BPS_THREE = 2'd3;
    localparam logic [BPS_W-1:0] BPS_RESET = BPS_THREE;

    // Byte counts carried with each queued word.
    localparam logic [COUNT_W-1:0] COUNT_NONE  = 2'd0;
    localparam logic [COUNT_W-1:0] COUNT_TWO   = 2'd2;
    localparam logic [COUNT_W-1:0] COUNT_THREE = 2'd3;

    // Default depth of the queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;

    // One classified word as it waits in the queue: the bytes to emit in
    // order (lane 0 first), how many of them, and the end-of-block flag.
    typedef struct packed {
        logic [LANES-1:0][BYTE_W-1:0] bytes;
        logic [COUNT_W-1:0]           count;
        logic                         last;
    } awrc_entry_t;

endpackage

// File: hdl/awrc_if.sv
// Sample word channel: one transaction carries one DMA word.
interface awrc_in_if;
    logic                             valid;
    logic                             ready;
    logic [awrc_pkg::WORD_W-1:0]      sample_word;
    logic                             block_end;

    modport source (output valid, output sample_word, output block_end, input ready);
    modport sink   (input valid, input sample_word, input block_end, output ready);
endinterface

// Byte channel: one transaction carries one packed byte and its checksum.
interface awrc_out_if;
    logic                             valid;
    logic                             ready;
    logic [awrc_pkg::BYTE_W-1:0]      out_byte;
    logic [awrc_pkg::BYTE_W-1:0]      running_sum;
    logic                             block_done;

    modport source (output valid, output out_byte, output running_sum, output block_done,
                    input ready);
    modport sink   (input valid, input out_byte, input running_sum, input block_done,
                    output ready);
endinterface

// File: hdl/awrc_front.sv
module awrc_front (
    input  logic                            clk,
    input  logic                            rst_n,
    awrc_in_if.sink                         sample_stream,
    input  logic                            bytes_per_sample_wr_en,
    input  logic [awrc_pkg::BPS_W-1:0]      bytes_per_sample_wr_data,
    input  logic                            queue_full,
    output logic                            push,
    output awrc_pkg::awrc_entry_t           push_entry
);

    logic [awrc_pkg::BPS_W-1:0] bps_reg;
    logic [awrc_pkg::BPS_W-1:0] bps_next;

    always_comb
    begin
        bps_next = bps_reg;
        if (bytes_per_sample_wr_en)
        begin
            bps_next = bytes_per_sample_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg <= awrc_pkg::BPS_RESET;
        end
        else
        begin
            bps_reg <= bps_next;
        end
    end

    assign sample_stream.ready = !queue_full;
    assign push                = sample_stream.valid && !queue_full;

    // Select the bytes to keep and how many; unsupported widths keep none
    // but the word is still queued so that its end-of-block flag takes effect.
    always_comb
    begin
        push_entry.last  = sample_stream.block_end;
        push_entry.bytes = sample_stream.sample_word[awrc_pkg::LANES*awrc_pkg::BYTE_W-1:0];
        push_entry.count = awrc_pkg::COUNT_NONE;
        case (bps_reg)
            awrc_pkg::BPS_THREE:
            begin
                push_entry.count = awrc_pkg::COUNT_THREE;
            end
            awrc_pkg::BPS_TWO:
            begin
                push_entry.bytes = sample_stream.sample_word[awrc_pkg::WORD_W-1:awrc_pkg::BYTE_W];
                push_entry.count = awrc_pkg::COUNT_TWO;
            end
            default:
            begin
                push_entry.count = awrc_pkg::COUNT_NONE;
            end
        endcase
    end

endmodule

// File: hdl/awrc_queue.sv
module awrc_queue #(
    parameter int DEPTH = awrc_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  awrc_pkg::awrc_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output awrc_pkg::awrc_entry_t head_entry,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    awrc_pkg::awrc_entry_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hdl/awrc_back.sv
module awrc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  awrc_pkg::awrc_entry_t head_entry,
    input  logic                  queue_empty,
    output logic                  pop,
    awrc_out_if.source            byte_stream
);

    logic [awrc_pkg::COUNT_W-1:0] idx_reg;
    logic [awrc_pkg::COUNT_W-1:0] idx_next;
    logic [awrc_pkg::BYTE_W-1:0]  sum_reg;
    logic [awrc_pkg::BYTE_W-1:0]  sum_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [awrc_pkg::BYTE_W-1:0]  out_byte_reg;
    logic [awrc_pkg::BYTE_W-1:0]  out_sum_reg;
    logic                         out_done_reg;

    logic                         head_valid;
    logic                         can_emit;
    logic                         emit;
    logic                         skip;
    logic                         is_final;
    logic [awrc_pkg::BYTE_W-1:0]  cur_byte;
    logic [awrc_pkg::BYTE_W-1:0]  sum_new;

    assign head_valid = !queue_empty;
    assign can_emit   = !out_valid_reg || byte_stream.ready;
    assign emit       = head_valid && (head_entry.count != awrc_pkg::COUNT_NONE) && can_emit;
    assign skip       = head_valid && (head_entry.count == awrc_pkg::COUNT_NONE);
    assign is_final   = (idx_reg == head_entry.count - awrc_pkg::COUNT_W'(1));
    assign pop        = skip || (emit && is_final);
    assign sum_new    = sum_reg + cur_byte;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_byte = head_entry.bytes[0];
            2'd1:    cur_byte = head_entry.bytes[1];
            default: cur_byte = head_entry.bytes[2];
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !byte_stream.ready;
        if (emit)
        begin
            out_valid_next = 1'b1;
            idx_next       = is_final ? '0 : idx_reg + awrc_pkg::COUNT_W'(1);
            sum_next       = (is_final && head_entry.last) ? '0 : sum_new;
        end
        else if (skip && head_entry.last)
        begin
            sum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_sum_reg  <= sum_new;
            out_done_reg <= is_final && head_entry.last;
        end
    end

    assign byte_stream.valid       = out_valid_reg;
    assign byte_stream.out_byte    = out_byte_reg;
    assign byte_stream.running_sum = out_sum_reg;
    assign byte_stream.block_done  = out_done_reg;

    // A word part-way through its bytes must still be at the head of the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> head_valid)
        else $error("byte index advanced with no word at the queue head");

    // The byte index always points inside the current word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && (head_entry.count != awrc_pkg::COUNT_NONE)) |-> (idx_reg < head_entry.count))
        else $error("byte index beyond the byte count of the head word");

    // Emitting the closing byte of a block leaves the checksum cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && is_final && head_entry.last) |=> (sum_reg == '0))
        else $error("checksum not cleared after the end of a block");

    // The block-end mark is only raised on the final byte of a flagged word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !(is_final && head_entry.last)) |=> !out_done_reg)
        else $error("block end flagged on a byte that does not close a block");

endmodule

// File: hdl/adc_word_repack_checksum.sv
// ADC word repacker with running checksum. Each sample_stream transaction
// carries one 32-bit DMA word (byte 0 in bits 7:0) and a block_end flag.
// With bytes_per_sample set to 3 (the reset value) the block emits bytes 0,
// 1 and 2 of the word; with 2 it emits bytes 1 and 2; with 0 or 1 it emits
// nothing. Each byte_stream transaction carries one byte, the 8-bit wrapping
// sum of all bytes of the current block up to and including it, and
// block_done on the final byte of a word flagged as the end of a block. The
// sum returns to zero after that word, also when the word emitted no bytes.
// The back end emits one byte per clock cycle while a word is queued and
// the output is not stalled; a word in an unsupported mode leaves the
// queue without emitting a byte. The first byte of a word passes through
// the queue and the output register before it appears on the output. A
// queue of QUEUE_DEPTH words separates the input from the output, so input
// words are still taken while a finished byte waits on a stalled output.
// Write bytes_per_sample only while no words are in flight.
module adc_word_repack_checksum #(
    parameter int QUEUE_DEPTH = awrc_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    awrc_in_if.sink                         sample_stream,
    awrc_out_if.source                      byte_stream,
    input  logic                            bytes_per_sample_wr_en,
    input  logic [awrc_pkg::BPS_W-1:0]      bytes_per_sample_wr_data
);

    // Handshake between the front end and the queue.
    logic                  push;
    logic                  queue_full;
    awrc_pkg::awrc_entry_t push_entry;

    // Handshake between the queue and the back end.
    logic                  pop;
    logic                  queue_empty;
    awrc_pkg::awrc_entry_t head_entry;

    // The front end holds the width register, accepts words and works out
    // which bytes each one contributes.
    awrc_front u_front (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .sample_stream            (sample_stream),
        .bytes_per_sample_wr_en   (bytes_per_sample_wr_en),
        .bytes_per_sample_wr_data (bytes_per_sample_wr_data),
        .queue_full               (queue_full),
        .push                     (push),
        .push_entry               (push_entry)
    );

    // The queue lets the front end keep accepting while the output stalls.
    awrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_entry (head_entry),
        .empty      (queue_empty)
    );

    // The back end walks the bytes of the head word, keeps the checksum and
    // drives the registered output.
    awrc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_entry  (head_entry),
        .queue_empty (queue_empty),
        .pop         (pop),
        .byte_stream (byte_stream)
    );

endmodule
